>>> hw/rtl/ucfp_pkg.sv
// Shared types and constants of the command frame parser.
// No dependencies; every other file of the block imports this package.
package ucfp_pkg;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned LEN_W     = 12;
   localparam int unsigned SUM_W     = 16;
   localparam int unsigned PHASE_W   = 4;
   localparam int unsigned ERR_W     = 2;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DAT_W = 12;

   localparam int unsigned LEN_LIMIT_DEFAULT = 2048;

   localparam logic [BYTE_W-1:0] HEAD_BYTE_RESET   = 8'h7E;
   localparam logic [BYTE_W-1:0] TAIL_BYTE_RESET   = 8'h0D;
   localparam logic [BYTE_W-1:0] EXEMPT_LOW_RESET  = 8'hFF;
   localparam logic [BYTE_W-1:0] EXEMPT_HIGH_RESET = 8'h00;

   // frame phases
   localparam logic [PHASE_W-1:0] PH_HUNT = 4'd0;
   localparam logic [PHASE_W-1:0] PH_VER  = 4'd1;
   localparam logic [PHASE_W-1:0] PH_SID  = 4'd2;
   localparam logic [PHASE_W-1:0] PH_DEST = 4'd3;
   localparam logic [PHASE_W-1:0] PH_CMD  = 4'd4;
   localparam logic [PHASE_W-1:0] PH_LENH = 4'd5;
   localparam logic [PHASE_W-1:0] PH_LENL = 4'd6;
   localparam logic [PHASE_W-1:0] PH_DATA = 4'd7;
   localparam logic [PHASE_W-1:0] PH_SUMH = 4'd8;
   localparam logic [PHASE_W-1:0] PH_SUML = 4'd9;
   localparam logic [PHASE_W-1:0] PH_TAIL = 4'd10;

   // verdict codes
   localparam logic [ERR_W-1:0] ERR_OK       = 2'd0;
   localparam logic [ERR_W-1:0] ERR_LENGTH   = 2'd1;
   localparam logic [ERR_W-1:0] ERR_TAIL     = 2'd2;
   localparam logic [ERR_W-1:0] ERR_CHECKSUM = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_HEAD_BYTE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TAIL_BYTE   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PAYLOAD = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_EXEMPT_LOW  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_EXEMPT_HIGH = 3'd4;

   typedef struct packed {
      logic [BYTE_W-1:0] head_byte;
      logic [BYTE_W-1:0] tail_byte;
      logic [LEN_W-1:0]  max_payload;
      logic [BYTE_W-1:0] exempt_cmd_low;
      logic [BYTE_W-1:0] exempt_cmd_high;
   } cfg_type;

   typedef struct packed {
      logic [BYTE_W-1:0] dest_addr;
      logic [BYTE_W-1:0] command;
      logic [BYTE_W-1:0] payload_byte;
      logic              is_payload;
      logic              frame_end;
      logic [ERR_W-1:0]  error_code;
   } rsp_type;

endpackage

>>> hw/rtl/ucfp_req_if.sv
// Byte input channel of the command frame parser.
// Depends on ucfp_pkg for the byte width.
interface ucfp_req_if;
   import ucfp_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

>>> hw/rtl/ucfp_rsp_if.sv
// Result channel of the command frame parser.
// Depends on ucfp_pkg for the field widths.
interface ucfp_rsp_if;
   import ucfp_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] dest_addr;
   logic [BYTE_W-1:0] command;
   logic [BYTE_W-1:0] payload_byte;
   logic              is_payload;
   logic              frame_end;
   logic [ERR_W-1:0]  error_code;

   modport source (output valid, output dest_addr, output command, output payload_byte,
                   output is_payload, output frame_end, output error_code, input ready);
   modport sink (input valid, input dest_addr, input command, input payload_byte,
                 input is_payload, input frame_end, input error_code, output ready);
endinterface

>>> hw/rtl/ucfp_csr_if.sv
// Register write channel of the command frame parser.
// Depends on ucfp_pkg for index and data widths.
interface ucfp_csr_if;
   import ucfp_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] reg_index;
   logic [CSR_DAT_W-1:0] wr_data;

   modport source (output valid, output reg_index, output wr_data, input ready);
   modport sink (input valid, input reg_index, input wr_data, output ready);
endinterface

>>> hw/rtl/ucfp_csr_regs.sv
// Configuration registers of the command frame parser.
// Depends on ucfp_pkg for register indexes, reset values and cfg_type.
module ucfp_csr_regs #(
   parameter int unsigned LEN_LIMIT = ucfp_pkg::LEN_LIMIT_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            wr_en,
   input  logic [ucfp_pkg::CSR_IDX_W-1:0]  wr_index,
   input  logic [ucfp_pkg::CSR_DAT_W-1:0]  wr_data,
   output ucfp_pkg::cfg_type               cfg
);
   import ucfp_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            CSR_HEAD_BYTE:   cfg_in.head_byte       = wr_data[BYTE_W-1:0];
            CSR_TAIL_BYTE:   cfg_in.tail_byte       = wr_data[BYTE_W-1:0];
            CSR_MAX_PAYLOAD: cfg_in.max_payload     = wr_data[LEN_W-1:0];
            CSR_EXEMPT_LOW:  cfg_in.exempt_cmd_low  = wr_data[BYTE_W-1:0];
            CSR_EXEMPT_HIGH: cfg_in.exempt_cmd_high = wr_data[BYTE_W-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.head_byte       <= HEAD_BYTE_RESET;
         cfg_ff.tail_byte       <= TAIL_BYTE_RESET;
         cfg_ff.max_payload     <= LEN_W'(LEN_LIMIT);
         cfg_ff.exempt_cmd_low  <= EXEMPT_LOW_RESET;
         cfg_ff.exempt_cmd_high <= EXEMPT_HIGH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> hw/rtl/ucfp_frame_fsm.sv
// Frame state machine: takes one byte per step, keeps the frame state and
// forms the result for that byte. Depends on ucfp_pkg.
module ucfp_frame_fsm #(
   parameter int unsigned LEN_LIMIT = ucfp_pkg::LEN_LIMIT_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step,
   input  logic [ucfp_pkg::BYTE_W-1:0]  step_byte,
   input  ucfp_pkg::cfg_type            cfg,
   output logic                         res_hit,
   output ucfp_pkg::rsp_type            res
);
   import ucfp_pkg::*;

   localparam logic [LEN_W-1:0] LIMIT_CAP = LEN_W'(LEN_LIMIT);

   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [BYTE_W-1:0]  dest_ff, dest_in;
   logic [BYTE_W-1:0]  cmd_ff, cmd_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [LEN_W-1:0]   count_ff, count_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [SUM_W-1:0]   rx_sum_ff, rx_sum_in;

   logic [SUM_W-1:0]   sum_add;
   logic [SUM_W-1:0]   frame_len;
   logic [LEN_W-1:0]   limit;
   logic [LEN_W-1:0]   count_inc;
   logic               exempt;

   assign sum_add   = sum_ff + SUM_W'(step_byte);
   assign frame_len = {len_ff[BYTE_W-1:0], step_byte};
   assign limit     = (cfg.max_payload > LIMIT_CAP) ? LIMIT_CAP : cfg.max_payload;
   assign count_inc = count_ff + LEN_W'(1);
   assign exempt    = (cmd_ff >= cfg.exempt_cmd_low) && (cmd_ff <= cfg.exempt_cmd_high);

   always_comb begin
      phase_in  = phase_ff;
      dest_in   = dest_ff;
      cmd_in    = cmd_ff;
      len_in    = len_ff;
      count_in  = count_ff;
      sum_in    = sum_ff;
      rx_sum_in = rx_sum_ff;
      res_hit   = 1'b0;
      res.dest_addr    = dest_ff;
      res.command      = cmd_ff;
      res.payload_byte = '0;
      res.is_payload   = 1'b0;
      res.frame_end    = 1'b0;
      res.error_code   = ERR_OK;

      case (phase_ff)
         PH_VER, PH_SID: begin
            sum_in   = sum_add;
            phase_in = phase_ff + PHASE_W'(1);
         end
         PH_DEST: begin
            sum_in   = sum_add;
            dest_in  = step_byte;
            phase_in = PH_CMD;
         end
         PH_CMD: begin
            sum_in   = sum_add;
            cmd_in   = step_byte;
            phase_in = PH_LENH;
         end
         PH_LENH: begin
            sum_in   = sum_add;
            len_in   = LEN_W'(step_byte);
            phase_in = PH_LENL;
         end
         PH_LENL: begin
            sum_in = sum_add;
            if (frame_len > SUM_W'(limit)) begin
               len_in         = '0;
               phase_in       = PH_HUNT;
               res_hit        = 1'b1;
               res.frame_end  = 1'b1;
               res.error_code = ERR_LENGTH;
            end else begin
               len_in   = frame_len[LEN_W-1:0];
               count_in = '0;
               phase_in = (frame_len == '0) ? PH_SUMH : PH_DATA;
            end
         end
         PH_DATA: begin
            sum_in   = sum_add;
            count_in = count_inc;
            if (count_inc >= len_ff) begin
               phase_in = PH_SUMH;
            end
            res_hit          = 1'b1;
            res.payload_byte = step_byte;
            res.is_payload   = 1'b1;
         end
         PH_SUMH: begin
            rx_sum_in = {step_byte, {BYTE_W{1'b0}}};
            phase_in  = PH_SUML;
         end
         PH_SUML: begin
            rx_sum_in = {rx_sum_ff[SUM_W-1:BYTE_W], step_byte};
            phase_in  = PH_TAIL;
         end
         PH_TAIL: begin
            phase_in      = PH_HUNT;
            res_hit       = 1'b1;
            res.frame_end = 1'b1;
            if (step_byte != cfg.tail_byte) begin
               res.error_code = ERR_TAIL;
            end else if (rx_sum_ff != sum_ff && !exempt) begin
               res.error_code = ERR_CHECKSUM;
            end else begin
               res.error_code = ERR_OK;
            end
         end
         default: begin
            // hunting, and any unused phase code
            if (step_byte == cfg.head_byte) begin
               sum_in    = SUM_W'(step_byte);
               count_in  = '0;
               len_in    = '0;
               rx_sum_in = '0;
               phase_in  = PH_VER;
            end else begin
               phase_in = PH_HUNT;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         dest_ff   <= '0;
         cmd_ff    <= '0;
         len_ff    <= '0;
         count_ff  <= '0;
         sum_ff    <= '0;
         rx_sum_ff <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         dest_ff   <= dest_in;
         cmd_ff    <= cmd_in;
         len_ff    <= len_in;
         count_ff  <= count_in;
         sum_ff    <= sum_in;
         rx_sum_ff <= rx_sum_in;
      end
   end

`ifndef SYNTHESIS
   a_verdict_returns_to_hunt: assert property (@(posedge clock) disable iff (reset)
      step && res_hit && res.frame_end |=> phase_ff == PH_HUNT)
      else $error("phase did not return to hunting after a verdict");

   a_payload_only_in_data: assert property (@(posedge clock) disable iff (reset)
      res_hit && res.is_payload |-> phase_ff == PH_DATA && !res.frame_end)
      else $error("payload result outside the data phase");

   a_data_has_length: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> len_ff != '0 && count_ff < len_ff)
      else $error("data phase with exhausted payload length");
`endif

endmodule

>>> hw/rtl/uart_command_frame_parser_unit.sv
// Serial command frame parser: takes one received byte per cycle and gives
// one result per payload byte and one verdict per frame. An accepted byte is
// held in an input register, runs through the frame state machine and, if it
// makes a result, lands in the output register, which offers it until it is
// taken. Throughput is one byte per cycle; the input side stalls only while the
// output register holds an untaken result and the waiting byte would make
// another. Register writes are always accepted and take effect once the
// configuration registers have loaded them.
module uart_command_frame_parser_unit #(
   parameter int unsigned LEN_LIMIT = ucfp_pkg::LEN_LIMIT_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   ucfp_req_if.sink          req_chan,
   ucfp_rsp_if.source        rsp_chan,
   ucfp_csr_if.sink          csr_chan
);
   import ucfp_pkg::*;

   logic              in_valid_ff;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              out_valid_ff;
   rsp_type           out_ff;

   cfg_type           cfg;
   logic              res_hit;
   rsp_type           res;
   logic              out_free;
   logic              step;

   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign step     = in_valid_ff && (!res_hit || out_free);

   assign req_chan.ready = !in_valid_ff || step;
   assign csr_chan.ready = 1'b1;

   ucfp_csr_regs #(
      .LEN_LIMIT (LEN_LIMIT)
   ) u_csr_regs (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_chan.valid),
      .wr_index (csr_chan.reg_index),
      .wr_data  (csr_chan.wr_data),
      .cfg      (cfg)
   );

   ucfp_frame_fsm #(
      .LEN_LIMIT (LEN_LIMIT)
   ) u_frame_fsm (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .step_byte (in_byte_ff),
      .cfg       (cfg),
      .res_hit   (res_hit),
      .res       (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_byte_ff <= req_chan.rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step && res_hit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step && res_hit) begin
         out_ff <= res;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.dest_addr    = out_ff.dest_addr;
   assign rsp_chan.command      = out_ff.command;
   assign rsp_chan.payload_byte = out_ff.payload_byte;
   assign rsp_chan.is_payload   = out_ff.is_payload;
   assign rsp_chan.frame_end    = out_ff.frame_end;
   assign rsp_chan.error_code   = out_ff.error_code;

`ifndef SYNTHESIS
   a_stalled_byte_kept: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !step |=> in_valid_ff && $stable(in_byte_ff))
      else $error("waiting byte lost from the input register");

   a_result_registered: assert property (@(posedge clock) disable iff (reset)
      step && res_hit |=> out_valid_ff)
      else $error("result not loaded into the output register");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_chan.ready |-> !(step && res_hit))
      else $error("untaken result overwritten");
`endif

endmodule

>>> bench/tb_top.sv
// Self-checking bench for the serial command frame parser: drives byte items,
// predicts payload and verdict results in step, and compares each taken result.
// Depends on ucfp_pkg, the three channel interfaces and uart_command_frame_parser_unit.
module tb_top;
   import ucfp_pkg::*;

   localparam int unsigned FRAME_LIMIT    = LEN_LIMIT_DEFAULT;
   localparam int unsigned HOLD_OFF_LEN   = 80;
   localparam int unsigned SETTLE_CYCLES  = 6;
   localparam int unsigned PHASE_ITEMS    = 50;

   logic clock;
   logic reset;

   ucfp_req_if req_chan ();
   ucfp_rsp_if rsp_chan ();
   ucfp_csr_if csr_chan ();

   uart_command_frame_parser_unit #(.LEN_LIMIT(FRAME_LIMIT)) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // parser state as the bench sees it
   cfg_type           shadow_cfg;
   logic [PHASE_W-1:0] frame_phase;
   logic [BYTE_W-1:0] frame_dest;
   logic [BYTE_W-1:0] frame_cmd;
   logic [LEN_W-1:0]  frame_len;
   logic [LEN_W-1:0]  payload_seen;
   logic [SUM_W-1:0]  sum_acc;
   logic [SUM_W-1:0]  sum_rx;

   rsp_type     due_results[$];
   int unsigned error_count = 0;
   int unsigned frame_bytes_sent = 0;
   int unsigned send_idle_pct = 37;
   int unsigned recv_stall_pct = 59;
   logic        receiver_held = 1'b0;
   event        hold_off_go;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3000000;
      $display("CHECK FAILED");
      $finish;
   end

   // long receiver stall so the parser backs up into its input
   initial forever begin
      @(hold_off_go);
      receiver_held <= 1'b1;
      repeat (HOLD_OFF_LEN) @(posedge clock);
      receiver_held <= 1'b0;
   end

   function automatic int unsigned length_limit();
      return (shadow_cfg.max_payload > FRAME_LIMIT) ? FRAME_LIMIT : shadow_cfg.max_payload;
   endfunction

   function automatic void reset_tracker();
      shadow_cfg.head_byte       = HEAD_BYTE_RESET;
      shadow_cfg.tail_byte       = TAIL_BYTE_RESET;
      shadow_cfg.max_payload     = LEN_W'(FRAME_LIMIT);
      shadow_cfg.exempt_cmd_low  = EXEMPT_LOW_RESET;
      shadow_cfg.exempt_cmd_high = EXEMPT_HIGH_RESET;
      frame_phase  = PH_HUNT;
      frame_dest   = '0;
      frame_cmd    = '0;
      frame_len    = '0;
      payload_seen = '0;
      sum_acc      = '0;
      sum_rx       = '0;
   endfunction

   function automatic void queue_result(input logic [BYTE_W-1:0] pay, input logic is_pay,
                                        input logic fin, input logic [ERR_W-1:0] err);
      rsp_type r;
      r.dest_addr    = frame_dest;
      r.command      = frame_cmd;
      r.payload_byte = pay;
      r.is_payload   = is_pay;
      r.frame_end    = fin;
      r.error_code   = err;
      due_results.push_back(r);
   endfunction

   function automatic void track_rx_byte(input logic [BYTE_W-1:0] b);
      logic [15:0] full_len;
      logic        exempt;
      case (frame_phase)
         PH_VER: begin
            sum_acc = sum_acc + SUM_W'(b);
            frame_phase = PH_SID;
         end
         PH_SID: begin
            sum_acc = sum_acc + SUM_W'(b);
            frame_phase = PH_DEST;
         end
         PH_DEST: begin
            sum_acc = sum_acc + SUM_W'(b);
            frame_dest = b;
            frame_phase = PH_CMD;
         end
         PH_CMD: begin
            sum_acc = sum_acc + SUM_W'(b);
            frame_cmd = b;
            frame_phase = PH_LENH;
         end
         PH_LENH: begin
            sum_acc = sum_acc + SUM_W'(b);
            frame_len = LEN_W'(b);
            frame_phase = PH_LENL;
         end
         PH_LENL: begin
            sum_acc = sum_acc + SUM_W'(b);
            full_len = {frame_len[7:0], b};
            if (full_len > length_limit()) begin
               frame_len = '0;
               frame_phase = PH_HUNT;
               queue_result('0, 1'b0, 1'b1, ERR_LENGTH);
            end else begin
               frame_len = full_len[LEN_W-1:0];
               payload_seen = '0;
               frame_phase = (frame_len == '0) ? PH_SUMH : PH_DATA;
            end
         end
         PH_DATA: begin
            sum_acc = sum_acc + SUM_W'(b);
            payload_seen = payload_seen + 1'b1;
            if (payload_seen >= frame_len) frame_phase = PH_SUMH;
            queue_result(b, 1'b1, 1'b0, ERR_OK);
         end
         PH_SUMH: begin
            sum_rx = {b, 8'h00};
            frame_phase = PH_SUML;
         end
         PH_SUML: begin
            sum_rx[7:0] = b;
            frame_phase = PH_TAIL;
         end
         PH_TAIL: begin
            frame_phase = PH_HUNT;
            exempt = (frame_cmd >= shadow_cfg.exempt_cmd_low) &&
                     (frame_cmd <= shadow_cfg.exempt_cmd_high);
            if (b != shadow_cfg.tail_byte) queue_result('0, 1'b0, 1'b1, ERR_TAIL);
            else if (sum_rx != sum_acc && !exempt) queue_result('0, 1'b0, 1'b1, ERR_CHECKSUM);
            else queue_result('0, 1'b0, 1'b1, ERR_OK);
         end
         default: begin
            if (b == shadow_cfg.head_byte) begin
               sum_acc = SUM_W'(b);
               payload_seen = '0;
               frame_len = '0;
               sum_rx = '0;
               frame_phase = PH_VER;
            end else begin
               frame_phase = PH_HUNT;
            end
         end
      endcase
   endfunction

   function automatic void compare_field(input string field_name, input logic [7:0] want,
                                         input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field_name, want, got);
         error_count++;
      end
   endfunction

   function automatic void check_result();
      rsp_type want;
      if (due_results.size() == 0) begin
         $display("%0t: result with none expected, actual dest %0h cmd %0h pay %0h end %0b err %0d",
                  $time, rsp_chan.dest_addr, rsp_chan.command, rsp_chan.payload_byte,
                  rsp_chan.frame_end, rsp_chan.error_code);
         error_count++;
         return;
      end
      want = due_results.pop_front();
      compare_field("dest_addr", want.dest_addr, rsp_chan.dest_addr);
      compare_field("command", want.command, rsp_chan.command);
      compare_field("payload_byte", want.payload_byte, rsp_chan.payload_byte);
      compare_field("is_payload", 8'(want.is_payload), 8'(rsp_chan.is_payload));
      compare_field("frame_end", 8'(want.frame_end), 8'(rsp_chan.frame_end));
      compare_field("error_code", 8'(want.error_code), 8'(rsp_chan.error_code));
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) check_result();
         rsp_chan.ready <= !receiver_held && ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   task automatic send_byte(input logic [BYTE_W-1:0] b);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.rx_byte <= b;
      do @(posedge clock); while (!req_chan.ready);
      track_rx_byte(b);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DAT_W-1:0] data);
      csr_chan.valid     <= 1'b1;
      csr_chan.reg_index <= idx;
      csr_chan.wr_data   <= data;
      do @(posedge clock); while (!csr_chan.ready);
      case (idx)
         CSR_HEAD_BYTE:   shadow_cfg.head_byte       = data[7:0];
         CSR_TAIL_BYTE:   shadow_cfg.tail_byte       = data[7:0];
         CSR_MAX_PAYLOAD: shadow_cfg.max_payload     = data[LEN_W-1:0];
         CSR_EXEMPT_LOW:  shadow_cfg.exempt_cmd_low  = data[7:0];
         CSR_EXEMPT_HIGH: shadow_cfg.exempt_cmd_high = data[7:0];
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [7:0] head, input logic [7:0] tail,
                             input logic [11:0] max_len, input logic [7:0] low,
                             input logic [7:0] high);
      write_register(CSR_HEAD_BYTE, 12'(head));
      write_register(CSR_TAIL_BYTE, 12'(tail));
      write_register(CSR_MAX_PAYLOAD, max_len);
      write_register(CSR_EXEMPT_LOW, 12'(low));
      write_register(CSR_EXEMPT_HIGH, 12'(high));
      csr_chan.valid <= 1'b0;
   endtask

   // waits out every due result plus the byte still in the pipeline
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // a frame stops after the length bytes when the length is over the limit;
   // cut keeps only that many leading bytes, 0 keeps the whole frame
   task automatic send_frame(input logic [7:0] dest, input logic [7:0] cmd,
                             input logic [15:0] len, input bit bad_sum, input bit bad_tail,
                             input int unsigned cut);
      logic [7:0]  frame_bytes[$];
      logic [15:0] sum;
      frame_bytes = {shadow_cfg.head_byte, 8'($urandom), 8'($urandom), dest, cmd,
                     len[15:8], len[7:0]};
      if (len <= length_limit()) begin
         repeat (len) frame_bytes.push_back(8'($urandom));
         sum = '0;
         foreach (frame_bytes[i]) sum = sum + 16'(frame_bytes[i]);
         if (bad_sum) sum = sum ^ (16'h1 << $urandom_range(0, 15));
         frame_bytes.push_back(sum[15:8]);
         frame_bytes.push_back(sum[7:0]);
         frame_bytes.push_back(bad_tail ? shadow_cfg.tail_byte ^ 8'($urandom_range(1, 255))
                                        : shadow_cfg.tail_byte);
      end
      if (cut != 0 && cut < frame_bytes.size()) frame_bytes = frame_bytes[0:cut-1];
      foreach (frame_bytes[i]) begin
         send_byte(frame_bytes[i]);
         frame_bytes_sent++;
      end
   endtask

   task automatic test_frame_basics();
      // line noise while hunting, then a short good frame and an empty one
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h0D);
      send_frame(8'hFF, 8'h00, 16'd3, 1'b0, 1'b0, 0);
      send_frame(8'h00, 8'hFF, 16'd0, 1'b0, 1'b0, 0);
      drain_results();
   endtask

   task automatic test_length_limit();
      send_frame(8'h12, 8'h34, 16'h0801, 1'b0, 1'b0, 0);
      send_frame(8'h56, 8'h78, 16'hFFFF, 1'b0, 1'b0, 0);
      drain_results();
      write_register(CSR_MAX_PAYLOAD, 12'd3);
      csr_chan.valid <= 1'b0;
      send_frame(8'h01, 8'h02, 16'd3, 1'b0, 1'b0, 0);
      send_frame(8'h03, 8'h04, 16'd4, 1'b0, 1'b0, 0);
      drain_results();
      write_register(CSR_MAX_PAYLOAD, 12'd0);
      csr_chan.valid <= 1'b0;
      send_frame(8'h05, 8'h06, 16'd0, 1'b0, 1'b0, 0);
      send_frame(8'h07, 8'h08, 16'd1, 1'b0, 1'b0, 0);
      drain_results();
      // a limit above the built-in one saturates
      write_register(CSR_MAX_PAYLOAD, 12'hFFF);
      csr_chan.valid <= 1'b0;
      send_frame(8'h09, 8'h0A, 16'(FRAME_LIMIT + 1), 1'b0, 1'b0, 0);
      drain_results();
      write_register(CSR_MAX_PAYLOAD, 12'(FRAME_LIMIT));
      csr_chan.valid <= 1'b0;
   endtask

   task automatic test_verdicts();
      send_frame(8'hA1, 8'h10, 16'd2, 1'b0, 1'b1, 0);
      send_frame(8'hA2, 8'h10, 16'd2, 1'b1, 1'b0, 0);
      send_frame(8'hA3, 8'h10, 16'd2, 1'b1, 1'b1, 0);
      drain_results();
      write_register(CSR_EXEMPT_LOW, 12'h010);
      write_register(CSR_EXEMPT_HIGH, 12'h020);
      csr_chan.valid <= 1'b0;
      send_frame(8'hB1, 8'h10, 16'd1, 1'b1, 1'b0, 0);
      send_frame(8'hB2, 8'h20, 16'd1, 1'b1, 1'b0, 0);
      send_frame(8'hB3, 8'h21, 16'd1, 1'b1, 1'b0, 0);
      send_frame(8'hB4, 8'h0F, 16'd1, 1'b1, 1'b0, 0);
      // exemption does not cover a bad tail
      send_frame(8'hB5, 8'h15, 16'd1, 1'b1, 1'b1, 0);
      drain_results();
   endtask

   task automatic test_mid_frame_write();
      logic [7:0]  part[$];
      logic [15:0] sum;
      sum = '0;
      part = {shadow_cfg.head_byte, 8'h01, 8'h02, 8'h33, 8'h44};
      foreach (part[i]) begin
         sum = sum + 16'(part[i]);
         send_byte(part[i]);
      end
      // frame left half done while the tail value changes
      drain_results();
      write_register(CSR_TAIL_BYTE, 12'h0FF);
      csr_chan.valid <= 1'b0;
      part = {8'h00, 8'h01, 8'hAB};
      foreach (part[i]) begin
         sum = sum + 16'(part[i]);
         send_byte(part[i]);
      end
      send_byte(sum[15:8]);
      send_byte(sum[7:0]);
      send_byte(8'hFF);
      drain_results();
      write_register(CSR_HEAD_BYTE, 12'h0A5);
      csr_chan.valid <= 1'b0;
      send_byte(8'h7E);
      send_frame(8'h5A, 8'h3C, 16'd2, 1'b0, 1'b0, 0);
      drain_results();
   endtask

   task automatic test_backpressure();
      int unsigned saved_idle;
      saved_idle = send_idle_pct;
      send_idle_pct = 0;
      -> hold_off_go;
      send_frame(8'h42, 8'h24, 16'd30, 1'b0, 1'b0, 0);
      send_idle_pct = saved_idle;
      drain_results();
   endtask

   task automatic send_random_frame();
      int unsigned lim;
      int unsigned len;
      int unsigned pick;
      int unsigned cut;
      logic [7:0]  cmd;
      lim  = length_limit();
      pick = $urandom_range(0, 99);
      if (pick < 8) len = $urandom_range(lim + 1, 16'hFFFF);
      else if (pick < 14) len = (lim <= 40) ? lim : $urandom_range(13, 40);
      else len = $urandom_range(0, (lim < 12) ? lim : 12);
      if ($urandom_range(0, 99) < 30 && shadow_cfg.exempt_cmd_low <= shadow_cfg.exempt_cmd_high)
         cmd = 8'($urandom_range(shadow_cfg.exempt_cmd_low, shadow_cfg.exempt_cmd_high));
      else
         cmd = 8'($urandom);
      if ($urandom_range(0, 99) < 15) repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
      cut = ($urandom_range(0, 99) < 6) ? $urandom_range(1, 9) : 0;
      send_frame(8'($urandom), cmd, 16'(len), $urandom_range(0, 99) < 20,
                 $urandom_range(0, 99) < 12, cut);
   endtask

   task automatic test_random_traffic();
      int unsigned mode_no;
      int unsigned phase_no;
      int unsigned target;
      for (mode_no = 0; mode_no < 3; mode_no++) begin
         case (mode_no)
            0: begin
               send_idle_pct = 37;
               recv_stall_pct = 59;
            end
            1: begin
               send_idle_pct = 59;
               recv_stall_pct = 37;
            end
            default: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
         endcase
         for (phase_no = 0; phase_no < 2; phase_no++) begin
            drain_results();
            if (mode_no == 0 && phase_no == 0)
               set_config(8'h00, 8'hFF, 12'hFFF, 8'h00, 8'hFF);
            else if (mode_no == 0)
               set_config(8'hFF, 8'h00, 12'd1, 8'hFF, 8'hFF);
            else
               set_config(($urandom_range(0, 3) == 0) ? HEAD_BYTE_RESET : 8'($urandom),
                          8'($urandom),
                          ($urandom_range(0, 9) == 0) ? 12'd0 : 12'($urandom_range(1, 30)),
                          8'($urandom), 8'($urandom));
            target = frame_bytes_sent + PHASE_ITEMS;
            while (frame_bytes_sent < target) send_random_frame();
         end
      end
      drain_results();
   endtask

   initial begin
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.rx_byte   = '0;
      rsp_chan.ready     = 1'b0;
      csr_chan.valid     = 1'b0;
      csr_chan.reg_index = '0;
      csr_chan.wr_data   = '0;
      reset_tracker();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_frame_basics();
      test_length_limit();
      test_verdicts();
      test_mid_frame_write();
      test_backpressure();
      test_random_traffic();

      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

>>> files.f
hw/rtl/ucfp_pkg.sv
hw/rtl/ucfp_req_if.sv
hw/rtl/ucfp_rsp_if.sv
hw/rtl/ucfp_csr_if.sv
hw/rtl/ucfp_csr_regs.sv
hw/rtl/ucfp_frame_fsm.sv
hw/rtl/uart_command_frame_parser_unit.sv
bench/tb_top.sv
